// ===== hw/rtl/iqhp_pkg.sv =====
// ----------------------------------------------------------------------------
// iqhp_pkg
// Shared types and constants for the IQ quantiser and code packer.
// ----------------------------------------------------------------------------
package iqhp_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int S_DATA_BITS  = 96;
    localparam int M_DATA_BITS  = 8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_MARKER = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    // Command to the packer row in this cycle.
    typedef struct packed {
        logic shift;
        logic bit_in;
        logic flush;
    } t_pack_ctl;

    // Byte produced by the packer row in this cycle.
    typedef struct packed {
        logic                 done;
        logic [BYTE_BITS-1:0] data;
    } t_pack_out;

endpackage

// ===== hw/rtl/iq_quantize_huffman_packer_top.sv =====
// ----------------------------------------------------------------------------
// iq_quantize_huffman_packer_top
// Nearest-level quantiser for IQ samples with variable-length codes and an
// MSB-first byte packer.
// ----------------------------------------------------------------------------
// A new beat is accepted only in idle, once the previous item is done. An encode
// scans the n entries in use one a cycle, then for each of the real and imaginary
// codes reads the entry and shifts out its bits, then releases the last byte; a
// marker sends the code of the last entry in use and a flush pads the partial byte.
// Output back-pressure stalls the bit shifting. Synchronous active-low reset
// clears the packer and sets the dictionary size to 1; tables are not cleared.
module iq_quantize_huffman_packer_top #(
    parameter int DICT_DEPTH    = 64,
    parameter int MAX_CODE_BITS = 32,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [6:0]                        i_cfg_data,   // dict_size
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // entry_index[5:0], entry_value[21:6], entry_code[53:22],
    // entry_code_length[59:54], sample_real[75:60], sample_imag[91:76]
    input  logic [iqhp_pkg::S_DATA_BITS-1:0]  i_s_tdata,
    input  logic [1:0]                        i_s_tuser,    // operation
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [iqhp_pkg::M_DATA_BITS-1:0]  o_m_tdata,    // out_byte
    output logic                              o_m_tlast     // last_byte
);
    import iqhp_pkg::*;

    localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int CB = MAX_CODE_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam int MW = SB + CB + LW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_WAIT, ST_RDW, ST_RD1, ST_SHIFT, ST_FLUSH, ST_END
    } t_state;

    t_state            r_st;
    logic [6:0]        r_dict;
    logic [AW-1:0]     r_raddr;
    logic [AW-1:0]     r_didx;
    logic              r_dv;
    logic [MW-1:0]     r_rd;
    logic [MW-1:0]     mem [DICT_DEPTH];
    logic signed [SB-1:0] r_sr, r_si;
    logic [AW-1:0]     r_br, r_bi;
    logic [SB:0]       r_dr, r_di;
    logic              r_imag;
    logic [CB-1:0]     r_code;
    logic [LW-1:0]     r_len;
    logic [7:0]        r_hold;
    logic              r_hold_v;
    logic              r_o_v;
    logic [7:0]        r_o_data;
    logic              r_o_last;

    t_pack_ctl         w_ctl;
    t_pack_out         w_pout;

    // Input field extraction.
    t_op               w_op;
    logic [5:0]        w_idx;
    logic [31:0]       w_v32, w_r32, w_i32;
    logic [63:0]       w_c64;
    logic [5:0]        w_len6;
    logic [LW-1:0]     w_len;
    logic [CB-1:0]     w_mask;
    logic              w_acc;
    logic [CW-1:0]     w_dext;
    logic [AW-1:0]     w_last;
    logic              w_out_busy;
    logic              w_stall;

    assign w_op   = t_op'(i_s_tuser);
    assign w_idx  = i_s_tdata[5:0];
    assign w_v32  = 32'($signed(i_s_tdata[21:6]));
    assign w_c64  = 64'(i_s_tdata[53:22]);
    assign w_len6 = i_s_tdata[59:54];
    assign w_r32  = 32'($signed(i_s_tdata[75:60]));
    assign w_i32  = 32'($signed(i_s_tdata[91:76]));
    assign w_acc  = i_s_tvalid && o_s_tready;

    assign o_s_tready  = (r_st == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (7'(w_len6) > 7'(MAX_CODE_BITS)) begin
            w_len = LW'(MAX_CODE_BITS);
        end else begin
            w_len = LW'(w_len6);
        end
        for (int j = 0; j < CB; j++) begin
            w_mask[j] = (j < int'(w_len));
        end
    end

    // Out-of-range sizes clamp to one entry or to the full table.
    assign w_dext = CW'(r_dict);
    always_comb begin
        priority if (w_dext == '0) begin
            w_last = '0;
        end else if (w_dext > CW'(DICT_DEPTH)) begin
            w_last = AW'(DICT_DEPTH - 1);
        end else begin
            w_last = AW'(w_dext - CW'(1));
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_op == OP_LOAD) && (CW'(w_idx) < CW'(DICT_DEPTH))) begin
            mem[AW'(w_idx)] <= {w_v32[SB-1:0], w_c64[CB-1:0] & w_mask, w_len};
        end
        r_rd <= mem[r_raddr];
    end

    // Distance compare for the entry read back in this cycle.
    logic signed [SB-1:0] w_lvl;
    logic signed [SB:0]   w_er, w_ei;
    logic [SB:0]          w_ar, w_ai;
    logic [AW-1:0]        n_br, n_bi;
    logic [SB:0]          n_dr, n_di;

    assign w_lvl = r_rd[MW-1 -: SB];

    always_comb begin
        w_er = $signed({r_sr[SB-1], r_sr}) - $signed({w_lvl[SB-1], w_lvl});
        w_ei = $signed({r_si[SB-1], r_si}) - $signed({w_lvl[SB-1], w_lvl});
        w_ar = w_er[SB] ? (SB+1)'(-w_er) : w_er;
        w_ai = w_ei[SB] ? (SB+1)'(-w_ei) : w_ei;
        n_br = r_br;
        n_bi = r_bi;
        n_dr = r_dr;
        n_di = r_di;
        if (r_dv) begin
            if ((r_didx == '0) || (w_ar < r_dr)) begin
                n_br = r_didx;
                n_dr = w_ar;
            end
            if ((r_didx == '0) || (w_ai < r_di)) begin
                n_bi = r_didx;
                n_di = w_ai;
            end
        end
    end

    assign w_out_busy = r_o_v && !i_m_tready;
    assign w_stall    = r_hold_v && w_out_busy;

    always_comb begin
        w_ctl.shift  = (r_st == ST_SHIFT) && (r_len != '0) && !w_stall;
        w_ctl.bit_in = r_code[CB-1];
        w_ctl.flush  = (r_st == ST_FLUSH) && !w_stall;
    end

    iqhp_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_out   (w_pout)
    );

    logic [CB-1:0] w_rcode;
    logic [LW-1:0] w_rlen;
    assign w_rcode = r_rd[LW +: CB];
    assign w_rlen  = r_rd[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_dict   <= 7'd1;
            r_dv     <= 1'b0;
            r_hold_v <= 1'b0;
            r_o_v    <= 1'b0;
            r_imag   <= 1'b0;
            r_raddr  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dict <= i_cfg_data;
            end
            r_dv   <= (r_st == ST_SCAN);
            r_didx <= r_raddr;
            r_br   <= n_br;
            r_bi   <= n_bi;
            r_dr   <= n_dr;
            r_di   <= n_di;

            if (r_o_v && i_m_tready) begin
                r_o_v <= 1'b0;
            end
            // A new byte pushes the held one out; the last one waits for
            // the end of the item so that it can carry the last flag.
            if (w_pout.done) begin
                if (r_hold_v) begin
                    r_o_v    <= 1'b1;
                    r_o_data <= r_hold;
                    r_o_last <= 1'b0;
                end
                r_hold   <= w_pout.data;
                r_hold_v <= 1'b1;
            end

            unique case (r_st)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_sr <= w_r32[SB-1:0];
                        r_si <= w_i32[SB-1:0];
                        unique case (w_op)
                            OP_LOAD: r_st <= ST_IDLE;
                            OP_ENCODE: begin
                                r_raddr <= '0;
                                r_imag  <= 1'b0;
                                r_st    <= ST_SCAN;
                            end
                            OP_MARKER: begin
                                r_raddr <= w_last;
                                r_imag  <= 1'b1;
                                r_st    <= ST_RDW;
                            end
                            OP_FLUSH: r_st <= ST_FLUSH;
                            default: r_st <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_raddr == w_last) begin
                        r_st <= ST_WAIT;
                    end else begin
                        r_raddr <= r_raddr + AW'(1);
                    end
                end
                ST_WAIT: begin
                    r_raddr <= n_br;
                    r_st    <= ST_RDW;
                end
                ST_RDW: r_st <= ST_RD1;
                ST_RD1: begin
                    r_code <= CB'(w_rcode << (LW'(CB) - w_rlen));
                    r_len  <= w_rlen;
                    r_st   <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    if (r_len == '0) begin
                        if (!r_imag) begin
                            r_imag  <= 1'b1;
                            r_raddr <= r_bi;
                            r_st    <= ST_RDW;
                        end else begin
                            r_st <= ST_END;
                        end
                    end else if (!w_stall) begin
                        r_code <= r_code << 1;
                        r_len  <= r_len - LW'(1);
                    end
                end
                ST_FLUSH: begin
                    if (!w_stall) begin
                        r_st <= ST_END;
                    end
                end
                ST_END: begin
                    if (!r_hold_v) begin
                        r_st <= ST_IDLE;
                    end else if (!w_out_busy) begin
                        r_o_v    <= 1'b1;
                        r_o_data <= r_hold;
                        r_o_last <= 1'b1;
                        r_hold_v <= 1'b0;
                        r_st     <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

    // No byte may be held back once the block takes a new item.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_hold_v)
        else $error("held byte left over at idle");

    // A byte only moves out of the hold register into a free output stage.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pout.done && r_hold_v) |-> !w_out_busy)
        else $error("output byte overwritten");

    // Scan reads never go past the last entry in use.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_didx <= w_last))
        else $error("scan index beyond dictionary size");

    // The byte released at the end of an item carries the last flag.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_END && r_hold_v && !w_out_busy) |=> (r_o_v && r_o_last))
        else $error("last byte not flagged");
endmodule

// ===== hw/rtl/iqhp_bit_cell.sv =====
// ----------------------------------------------------------------------------
// iqhp_bit_cell
// One pending bit of the packer; passes its bit to the next cell on a shift.
// ----------------------------------------------------------------------------
module iqhp_bit_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_clear,
    input  logic i_bit,
    output logic o_bit
);
    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_clear) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;
endmodule

// ===== hw/rtl/iqhp_packer.sv =====
// ----------------------------------------------------------------------------
// iqhp_packer
// Row of seven bit cells with a fill count; forms a byte on the eighth bit
// or pads the partial byte with zeros on a flush.
// ----------------------------------------------------------------------------
module iqhp_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iqhp_pkg::t_pack_ctl i_ctl,
    output iqhp_pkg::t_pack_out o_out
);
    import iqhp_pkg::*;

    localparam int NCELL = BYTE_BITS - 1;

    logic [NCELL-1:0] w_bits;
    logic [NCELL-1:0] w_chain;
    logic [2:0]       r_cnt;
    logic             w_full;
    logic             w_clear;

    assign w_chain = {w_bits[NCELL-2:0], i_ctl.bit_in};
    assign w_full  = i_ctl.shift && (r_cnt == 3'(NCELL));
    assign w_clear = w_full || (i_ctl.flush && (r_cnt != 3'd0));

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        iqhp_bit_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_ctl.shift),
            .i_clear (w_clear),
            .i_bit   (w_chain[k]),
            .o_bit   (w_bits[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (w_clear) begin
            r_cnt <= 3'd0;
        end else if (i_ctl.shift) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // Cell 0 holds the newest bit, so the oldest bit lands in bit 7.
    always_comb begin
        o_out.done = w_clear;
        if (w_full) begin
            o_out.data = {w_bits, i_ctl.bit_in};
        end else begin
            o_out.data = 8'({1'b0, w_bits} << (4'd8 - {1'b0, r_cnt}));
        end
    end
endmodule
